@@ hdl/msg_pkg.sv @@
package msg_pkg;

    // field and datapath widths
    localparam int ROW_W      = 13;
    localparam int CFG_W      = 12;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int OFF_W      = 16;
    localparam int CH_W       = 8;
    localparam int COL_W      = 3 * CH_W;
    localparam int PROD_W     = OFF_W + CFG_W;
    localparam int DIV_STEPS  = CH_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;

    localparam int MAX_STOPS_DEF = 16;
    localparam int MIN_STOPS     = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT  = 2'd2;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] TOP_RST    = 12'd0;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd1;
    localparam logic [CNT_W-1:0] COUNT_RST  = 5'd2;

    // item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_SHADE = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] stop_index;
        logic [OFF_W-1:0] stop_position;
        logic [CH_W-1:0]  stop_red;
        logic [CH_W-1:0]  stop_green;
        logic [CH_W-1:0]  stop_blue;
        logic [ROW_W-1:0] row;
    } in_word_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANGE,
        ST_END_RD,
        ST_MUL,
        ST_TEST,
        ST_BMUL,
        ST_BDIV,
        ST_BRES,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_FIRST,
        RD_LAST,
        RD_NEXT
    } rd_sel_t;

    typedef struct packed {
        logic    stop_wr;
        logic    cap_row;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    start_search;
        logic    mul;
        logic    advance;
        logic    load_frac;
        logic    blend_load;
        logic    blend_step;
        logic    res_from_rd;
        logic    res_from_blend;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic below_top;
        logic beyond;
        logic hit;
        logic first;
        logic last;
        logic degenerate;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/msg_blend_lane.sv @@
// one color channel: c0 +/- trunc(|c1 - c0| * num / den), one quotient bit a cycle while step is high
module msg_blend_lane (
    input  logic                            clk,
    input  logic [msg_pkg::CH_W-1:0]        c0,
    input  logic [msg_pkg::CH_W-1:0]        c1,
    input  logic [msg_pkg::PROD_W-1:0]      num,
    input  logic [msg_pkg::PROD_W-1:0]      den,
    input  logic                            load,
    input  logic                            step,
    output logic [msg_pkg::CH_W-1:0]        result
);

    localparam int CH_W   = msg_pkg::CH_W;
    localparam int PROD_W = msg_pkg::PROD_W;
    localparam int P_W    = CH_W + PROD_W;

    logic              neg;
    logic [CH_W-1:0]   diff;
    logic [P_W-1:0]    prod;
    logic [PROD_W:0]   trial;
    logic [PROD_W:0]   trial_sub;
    logic              fits;

    logic              neg_reg;
    logic [CH_W-1:0]   c0_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] rem_next;
    logic [CH_W-1:0]   low_reg;
    logic [CH_W-1:0]   q_reg;
    logic [CH_W-1:0]   q_next;

    assign neg  = c1 < c0;
    assign diff = neg ? (c0 - c1) : (c1 - c0);
    assign prod = P_W'(diff) * P_W'(num);

    // quotient stays below 256 since num <= den, so the upper part starts below den
    assign trial     = {rem_reg, low_reg[CH_W-1]};
    assign fits      = trial >= {1'b0, den};
    assign trial_sub = trial - {1'b0, den};
    assign rem_next  = fits ? trial_sub[PROD_W-1:0] : trial[PROD_W-1:0];
    assign q_next    = {q_reg[CH_W-2:0], fits};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg <= neg;
            c0_reg  <= c0;
            rem_reg <= prod[P_W-1:CH_W];
            low_reg <= prod[CH_W-1:0];
            q_reg   <= '0;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[CH_W-2:0], 1'b0};
            q_reg   <= q_next;
        end
    end

    assign result = neg_reg ? (c0_reg - q_reg) : (c0_reg + q_reg);

endmodule

@@ hdl/msg_ctrl.sv @@
// sequencer: stop writes, range check, stop search, interpolation, output hand-off
module msg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_mode,
    output logic          in_ready,
    output msg_pkg::cmd_t cmd,
    input  msg_pkg::sts_t sts
);

    localparam int DIV_CNT_W = msg_pkg::DIV_CNT_W;

    msg_pkg::state_t      state_reg;
    msg_pkg::state_t      state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= msg_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            msg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == msg_pkg::MODE_SHADE)
                    begin
                        cmd.cap_row = 1'b1;
                        state_next  = msg_pkg::ST_RANGE;
                    end
                    else
                    begin
                        cmd.stop_wr = 1'b1;
                    end
                end
            end
            msg_pkg::ST_RANGE:
            begin
                cmd.rd_en = 1'b1;
                if (sts.below_top)
                begin
                    cmd.rd_sel = msg_pkg::RD_FIRST;
                    state_next = msg_pkg::ST_END_RD;
                end
                else if (sts.beyond)
                begin
                    cmd.rd_sel = msg_pkg::RD_LAST;
                    state_next = msg_pkg::ST_END_RD;
                end
                else
                begin
                    cmd.rd_sel       = msg_pkg::RD_FIRST;
                    cmd.start_search = 1'b1;
                    state_next       = msg_pkg::ST_MUL;
                end
            end
            msg_pkg::ST_END_RD:
            begin
                cmd.res_from_rd = 1'b1;
                state_next      = msg_pkg::ST_OUT;
            end
            msg_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = msg_pkg::ST_TEST;
            end
            msg_pkg::ST_TEST:
            begin
                if (sts.hit)
                begin
                    if (sts.first || sts.degenerate)
                    begin
                        cmd.res_from_rd = 1'b1;
                        state_next      = msg_pkg::ST_OUT;
                    end
                    else
                    begin
                        cmd.load_frac = 1'b1;
                        state_next    = msg_pkg::ST_BMUL;
                    end
                end
                else if (sts.last)
                begin
                    // no stop reached: the entry just read is the last one
                    cmd.res_from_rd = 1'b1;
                    state_next      = msg_pkg::ST_OUT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = msg_pkg::RD_NEXT;
                    state_next  = msg_pkg::ST_MUL;
                end
            end
            msg_pkg::ST_BMUL:
            begin
                cmd.blend_load = 1'b1;
                div_cnt_next   = '0;
                state_next     = msg_pkg::ST_BDIV;
            end
            msg_pkg::ST_BDIV:
            begin
                cmd.blend_step = 1'b1;
                div_cnt_next   = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(msg_pkg::DIV_STEPS - 1))
                begin
                    state_next = msg_pkg::ST_BRES;
                end
            end
            msg_pkg::ST_BRES:
            begin
                cmd.res_from_blend = 1'b1;
                state_next         = msg_pkg::ST_OUT;
            end
            msg_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = msg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/msg_datapath.sv @@
// config registers, stop ram, search arithmetic, blend lanes, output register
module msg_datapath #(
    parameter int MAX_STOPS = msg_pkg::MAX_STOPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  msg_pkg::in_word_t                in_data,
    input  logic                             cfg_we,
    input  logic [msg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msg_pkg::CFG_W-1:0]        cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output msg_pkg::out_word_t               out_data,
    input  msg_pkg::cmd_t                    cmd,
    output msg_pkg::sts_t                    sts
);

    localparam int AW     = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CW     = $clog2(MAX_STOPS + 1);
    localparam int ROW_W  = msg_pkg::ROW_W;
    localparam int CFG_W  = msg_pkg::CFG_W;
    localparam int CNT_W  = msg_pkg::CNT_W;
    localparam int OFF_W  = msg_pkg::OFF_W;
    localparam int CH_W   = msg_pkg::CH_W;
    localparam int COL_W  = msg_pkg::COL_W;
    localparam int PROD_W = msg_pkg::PROD_W;

    logic [CFG_W-1:0]  top_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [OFF_W-1:0]  off_mem [MAX_STOPS];
    logic [COL_W-1:0]  col_mem [MAX_STOPS];
    logic [OFF_W-1:0]  rd_off_reg;
    logic [COL_W-1:0]  rd_col_reg;

    logic [ROW_W-1:0]  row_reg;
    logic [PROD_W-1:0] scaled_reg;
    logic [AW-1:0]     idx_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prev_prod_reg;
    logic [COL_W-1:0]  prev_col_reg;
    logic [PROD_W-1:0] num_reg;
    logic [PROD_W-1:0] den_reg;
    logic [COL_W-1:0]  res_reg;
    logic              out_valid_reg;
    logic [COL_W-1:0]  out_data_reg;

    logic              wr_ok;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     used;
    logic [AW-1:0]     last_idx;
    logic [ROW_W-1:0]  bottom;
    logic [ROW_W-1:0]  d_full;
    logic [PROD_W-1:0] scaled_next;
    logic [CH_W-1:0]   red_mix;
    logic [CH_W-1:0]   green_mix;
    logic [CH_W-1:0]   blue_mix;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= msg_pkg::TOP_RST;
            height_reg <= msg_pkg::HEIGHT_RST;
            count_reg  <= msg_pkg::COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                msg_pkg::CFG_RECT_TOP:    top_reg    <= cfg_data;
                msg_pkg::CFG_RECT_HEIGHT: height_reg <= cfg_data;
                msg_pkg::CFG_STOP_COUNT:  count_reg  <= cfg_data[CNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // stops in use, clamped to the table
    always_comb
    begin
        if (count_reg < CNT_W'(msg_pkg::MIN_STOPS))
            used = CW'(msg_pkg::MIN_STOPS);
        else if (32'(count_reg) > 32'(MAX_STOPS))
            used = CW'(MAX_STOPS);
        else
            used = CW'(count_reg);
    end

    assign last_idx = AW'(used - 1'b1);

    // stop table
    assign wr_ok   = 32'(in_data.stop_index) < 32'(MAX_STOPS);
    assign wr_addr = AW'(in_data.stop_index);

    always_comb
    begin
        unique case (cmd.rd_sel)
            msg_pkg::RD_FIRST: rd_addr = '0;
            msg_pkg::RD_LAST:  rd_addr = last_idx;
            msg_pkg::RD_NEXT:  rd_addr = idx_reg + 1'b1;
            default:           rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.stop_wr && wr_ok)
        begin
            off_mem[wr_addr] <= in_data.stop_position;
            col_mem[wr_addr] <= {in_data.stop_red, in_data.stop_green, in_data.stop_blue};
        end
        if (cmd.rd_en)
        begin
            rd_off_reg <= off_mem[rd_addr];
            rd_col_reg <= col_mem[rd_addr];
        end
    end

    // row position: d = row - top, scaled = d * 65535
    assign bottom      = ROW_W'(top_reg) + ROW_W'(height_reg);
    assign d_full      = row_reg - ROW_W'(top_reg);
    assign scaled_next = {d_full[CFG_W-1:0], {OFF_W{1'b0}}} - PROD_W'(d_full[CFG_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_row)
            row_reg <= in_data.row;
        if (cmd.start_search)
        begin
            scaled_reg <= scaled_next;
            idx_reg    <= '0;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(rd_off_reg) * PROD_W'(height_reg);
        if (cmd.advance)
        begin
            idx_reg       <= idx_reg + 1'b1;
            prev_prod_reg <= prod_reg;
            prev_col_reg  <= rd_col_reg;
        end
        if (cmd.load_frac)
        begin
            num_reg <= scaled_reg - prev_prod_reg;
            den_reg <= prod_reg - prev_prod_reg;
        end
        if (cmd.res_from_rd)
            res_reg <= rd_col_reg;
        else if (cmd.res_from_blend)
            res_reg <= {red_mix, green_mix, blue_mix};
    end

    msg_blend_lane u_lane_red (
        .clk    (clk),
        .c0     (prev_col_reg[COL_W-1:2*CH_W]),
        .c1     (rd_col_reg[COL_W-1:2*CH_W]),
        .num    (num_reg),
        .den    (den_reg),
        .load   (cmd.blend_load),
        .step   (cmd.blend_step),
        .result (red_mix)
    );

    msg_blend_lane u_lane_green (
        .clk    (clk),
        .c0     (prev_col_reg[2*CH_W-1:CH_W]),
        .c1     (rd_col_reg[2*CH_W-1:CH_W]),
        .num    (num_reg),
        .den    (den_reg),
        .load   (cmd.blend_load),
        .step   (cmd.blend_step),
        .result (green_mix)
    );

    msg_blend_lane u_lane_blue (
        .clk    (clk),
        .c0     (prev_col_reg[CH_W-1:0]),
        .c1     (rd_col_reg[CH_W-1:0]),
        .num    (num_reg),
        .den    (den_reg),
        .load   (cmd.blend_load),
        .step   (cmd.blend_step),
        .result (blue_mix)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = msg_pkg::out_word_t'(out_data_reg);

    // status
    assign sts.below_top  = row_reg <= ROW_W'(top_reg);
    assign sts.beyond     = bottom < row_reg;
    assign sts.hit        = scaled_reg <= prod_reg;
    assign sts.first      = idx_reg == '0;
    assign sts.last       = (CW'(idx_reg) + CW'(1)) == used;
    assign sts.degenerate = (prod_reg <= prev_prod_reg) || (scaled_reg < prev_prod_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a word not yet taken");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_frac |=> den_reg != '0)
        else $error("interpolation started on an empty span");

    a_num_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_frac |=> num_reg <= den_reg)
        else $error("interpolation fraction above one");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en && cmd.rd_sel == msg_pkg::RD_NEXT) |-> (CW'(idx_reg) + CW'(1)) < used)
        else $error("stop search ran past the stops in use");

endmodule

@@ hdl/multi_stop_gradient_shader.sv @@
// stop write word: taken when offered while idle, no result, ready again next cycle
// shade word: rows outside the rectangle take the first or last stop color directly;
//   other rows search the stop ram entry by entry until a stop is reached or the last
//   one is tested, then take that stop's color or blend it with the stop before it;
// one word in flight at a time; a finished word waits in the output register
// reset (rst_n, async, active low): top 0, height 1, two stops; stop table holds garbage
module multi_stop_gradient_shader #(
    parameter int MAX_STOPS = msg_pkg::MAX_STOPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input words: stop writes and shade requests
    input  logic                          in_valid,
    output logic                          in_ready,
    input  msg_pkg::in_word_t             in_data,
    // output words: one color per shade request
    output logic                          out_valid,
    input  logic                          out_ready,
    output msg_pkg::out_word_t            out_data,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [msg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msg_pkg::CFG_W-1:0]     cfg_data
);

    // command and status between sequencer and datapath
    msg_pkg::cmd_t cmd;
    msg_pkg::sts_t sts;

    // sequencer: walks one word through range check, search and blend
    msg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (in_data.mode),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath: config, stop ram, row-to-fraction math, three serial dividers
    msg_datapath #(
        .MAX_STOPS (MAX_STOPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int ROW_W     = msg_pkg::ROW_W;
    localparam int CFG_W     = msg_pkg::CFG_W;
    localparam int CNT_W     = msg_pkg::CNT_W;
    localparam int IDX_W     = msg_pkg::IDX_W;
    localparam int OFF_W     = msg_pkg::OFF_W;
    localparam int CH_W      = msg_pkg::CH_W;
    localparam int COL_W     = msg_pkg::COL_W;
    localparam int CFG_IDX_W = msg_pkg::CFG_IDX_W;

    // register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // cycles with no word moving on either side before the run is called hung
    localparam int IDLE_LIMIT = 4000;
    // wait after the owed colors drain before touching registers
    localparam int HOLD_OFF   = 48;
    localparam int TAB_DEPTH  = msg_pkg::MAX_STOPS_DEF;
    localparam int WORDS_PER_PHASE = 100;
    localparam int PHASES     = 10;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    msg_pkg::in_word_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    msg_pkg::out_word_t out_data;
    logic               cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    // shadow copy of the registers and the stop table
    logic [CFG_W-1:0]   top_row   = msg_pkg::TOP_RST;
    logic [CFG_W-1:0]   span_rows = msg_pkg::HEIGHT_RST;
    logic [CNT_W-1:0]   stops_set = msg_pkg::COUNT_RST;
    logic [OFF_W-1:0]   offset_tab [TAB_DEPTH];
    logic [COL_W-1:0]   color_tab  [TAB_DEPTH];

    // colors owed by the block, oldest first
    msg_pkg::out_word_t colors_due [$];

    int                 err_count   = 0;
    int                 burst_left  = 0;
    int                 idle_cycles = 0;
    int                 stall_left  = 0;
    int                 stall_mode  = 0;
    int unsigned        pat_cnt     = 0;

    multi_stop_gradient_shader u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // color prediction
    // ------------------------------------------------------------------

    // one channel: c0 moved toward c1 by num/den, rounded toward c0
    function automatic logic [CH_W-1:0] blend_channel(input logic [CH_W-1:0] c0,
                                                      input logic [CH_W-1:0] c1,
                                                      input longint unsigned num,
                                                      input longint unsigned den);
        longint unsigned diff;
        longint unsigned stepv;
        if (c1 >= c0)
        begin
            diff  = 64'(c1 - c0);
            stepv = diff * num / den;
            return c0 + stepv[CH_W-1:0];
        end
        diff  = 64'(c0 - c1);
        stepv = diff * num / den;
        return c0 - stepv[CH_W-1:0];
    endfunction

    function automatic msg_pkg::out_word_t shade_row(input logic [ROW_W-1:0] row);
        int unsigned     used;
        int unsigned     i;
        int unsigned     r;
        int unsigned     top;
        int unsigned     span;
        longint unsigned h;
        longint unsigned scaled;
        longint unsigned oi;
        longint unsigned o0;
        longint unsigned o1;
        longint unsigned num;
        longint unsigned den;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] c0;
        logic [COL_W-1:0] c1;
        logic [COL_W-1:0] last;
        msg_pkg::out_word_t res;

        // stop count saturates to the table limits
        used = 32'(stops_set);
        if (used < msg_pkg::MIN_STOPS)
            used = msg_pkg::MIN_STOPS;
        if (used > TAB_DEPTH)
            used = TAB_DEPTH;

        r    = 32'(row);
        top  = 32'(top_row);
        span = 32'(span_rows);
        h    = 64'(span_rows);
        last = color_tab[used-1];

        if (r <= top)
            col = color_tab[0];             // at or above the top
        else if (top + span < r)
            col = last;                     // below the bottom
        else
        begin
            // exact compare of d/height against each stop offset
            scaled = 64'(r - top) * 65535;
            for (i = 0; i < used; i++)
            begin
                oi = 64'(offset_tab[i]);
                if (scaled <= oi * h)
                    break;
            end
            if (i == used)
                col = last;                 // no stop reached
            else if (i == 0)
                col = color_tab[0];         // first stop already reached
            else
            begin
                o0 = 64'(offset_tab[i-1]);
                o1 = 64'(offset_tab[i]);
                c0 = color_tab[i-1];
                c1 = color_tab[i];
                if (o1 <= o0 || scaled < o0 * h)
                    col = c1;
                else
                begin
                    num = scaled - o0 * h;
                    den = (o1 - o0) * h;
                    if (den == 0)
                        col = c1;           // zero-height span
                    else
                    begin
                        if (num > den)
                            num = den;
                        col = {blend_channel(c0[23:16], c1[23:16], num, den),
                               blend_channel(c0[15:8],  c1[15:8],  num, den),
                               blend_channel(c0[7:0],   c1[7:0],   num, den)};
                    end
                end
            end
        end

        res.red   = col[23:16];
        res.green = col[15:8];
        res.blue  = col[7:0];
        return res;
    endfunction

    // accepted word: update the table or queue the color it owes
    function automatic void take_word(input msg_pkg::in_word_t w);
        if (w.mode == msg_pkg::MODE_SHADE)
            colors_due.push_back(shade_row(w.row));
        else
        begin
            offset_tab[w.stop_index] = w.stop_position;
            color_tab[w.stop_index]  = {w.stop_red, w.stop_green, w.stop_blue};
        end
    endfunction

    // ------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------

    // unused fields carry random bits so every bit toggles
    function automatic msg_pkg::in_word_t make_stop(input int idx, input int off,
                                                    input logic [COL_W-1:0] rgb);
        msg_pkg::in_word_t w;
        w.mode          = msg_pkg::MODE_WRITE;
        w.stop_index    = IDX_W'(idx);
        w.stop_position = OFF_W'(off);
        w.stop_red      = rgb[23:16];
        w.stop_green    = rgb[15:8];
        w.stop_blue     = rgb[7:0];
        w.row           = ROW_W'($urandom);
        return w;
    endfunction

    function automatic msg_pkg::in_word_t make_shade(input int row);
        msg_pkg::in_word_t w;
        w.mode          = msg_pkg::MODE_SHADE;
        w.stop_index    = IDX_W'($urandom);
        w.stop_position = OFF_W'($urandom);
        w.stop_red      = CH_W'($urandom);
        w.stop_green    = CH_W'($urandom);
        w.stop_blue     = CH_W'($urandom);
        w.row           = ROW_W'(row);
        return w;
    endfunction

    // ramp from black to white in red, the reverse in green, alternating blue
    function automatic logic [COL_W-1:0] ramp_color(input int i);
        logic [CH_W-1:0] r;
        r = CH_W'(i * 17);
        return {r, 8'(255 - i * 17), (i % 2 == 1) ? 8'hFF : 8'h00};
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, want %0d", what, got, want);
        err_count++;
    endtask

    // offer one word; bursts of back-to-back words split by random gaps
    task automatic send_word(input msg_pkg::in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        take_word(w);
    endtask

    // block idle: no color owed and the last word worked off
    task automatic settle();
        in_valid <= 1'b0;
        while (colors_due.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            msg_pkg::CFG_RECT_TOP:    top_row   = val;
            msg_pkg::CFG_RECT_HEIGHT: span_rows = val;
            msg_pkg::CFG_STOP_COUNT:  stops_set = val[CNT_W-1:0];
            default:                  ;
        endcase
    endtask

    task automatic set_rect(input int top, input int height, input int count);
        set_reg(msg_pkg::CFG_RECT_TOP, CFG_W'(top));
        set_reg(msg_pkg::CFG_RECT_HEIGHT, CFG_W'(height));
        set_reg(msg_pkg::CFG_STOP_COUNT, CFG_W'(count));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // fill every entry first so no shade ever reads an unwritten stop
    task automatic test_stop_table();
        int i;
        for (i = 0; i < TAB_DEPTH; i++)
            send_word(make_stop(i, i * 4369, ramp_color(i)));
    endtask

    task automatic test_rect_edges();
        // reset settings: top 0, one row, two stops
        send_word(make_shade(0));
        send_word(make_shade(1));
        send_word(make_shade(2));
        send_word(make_shade(8191));
        // largest rectangle at the largest top, full table
        settle();
        set_rect(4095, 4095, 16);
        send_word(make_shade(4095));
        send_word(make_shade(4096));
        send_word(make_shade(8190));
        send_word(make_shade(8191));
    endtask

    task automatic test_stop_count_limits();
        settle();
        set_rect(100, 200, 0);
        send_word(make_shade(150));
        settle();
        set_reg(msg_pkg::CFG_STOP_COUNT, CFG_W'(1));
        send_word(make_shade(150));
        settle();
        set_reg(msg_pkg::CFG_STOP_COUNT, CFG_W'(31));
        send_word(make_shade(299));
        settle();
        // undecoded index must leave every register alone
        set_reg(CFG_UNUSED, 12'hFFF);
        send_word(make_shade(150));
    endtask

    task automatic test_stop_reach();
        settle();
        set_reg(msg_pkg::CFG_STOP_COUNT, CFG_W'(4));
        // last offset in use is below the bottom fraction
        send_word(make_shade(300));
        send_word(make_shade(110));
        // first stop at one covers the whole rectangle
        send_word(make_stop(0, 16'hFFFF, ramp_color(0)));
        send_word(make_shade(150));
        send_word(make_stop(0, 0, ramp_color(0)));
        // two stops at the same offset
        send_word(make_stop(2, 4369, ramp_color(2)));
        send_word(make_shade(113));
        send_word(make_shade(114));
        send_word(make_stop(2, 2 * 4369, ramp_color(2)));
    endtask

    task automatic test_zero_height();
        settle();
        set_rect(50, 0, 16);
        send_word(make_shade(50));
        send_word(make_shade(51));
    endtask

    // each phase: new settings, an ordered table, then mostly shades
    task automatic run_random_phase(input int p);
        int unsigned cfg_top;
        int unsigned cfg_h;
        int unsigned cfg_cnt;
        int unsigned used;
        int unsigned lo;
        int unsigned hi;
        int          k;
        int          pick;
        logic [OFF_W-1:0] offs [$];

        case (p)
            0:
            begin
                cfg_top = 0;
                cfg_h   = 4095;
                cfg_cnt = 16;
            end
            1:
            begin
                cfg_top = 4095;
                cfg_h   = 1;
                cfg_cnt = 2;
            end
            2:
            begin
                cfg_top = $urandom_range(0, 4095);
                cfg_h   = 0;
                cfg_cnt = 8;
            end
            3:
            begin
                cfg_top = 0;
                cfg_h   = 1;
                cfg_cnt = 31;
            end
            default:
            begin
                cfg_top = $urandom_range(0, 4095);
                cfg_h   = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                                      : $urandom_range(1, 4095);
                cfg_cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(2, 16);
            end
        endcase
        settle();
        set_rect(cfg_top, cfg_h, cfg_cnt);

        used = cfg_cnt;
        if (used < msg_pkg::MIN_STOPS)
            used = msg_pkg::MIN_STOPS;
        if (used > TAB_DEPTH)
            used = TAB_DEPTH;

        // well-formed table: ascending offsets, sometimes pinned to zero and one
        for (k = 0; k < used; k++)
            offs.push_back(OFF_W'($urandom));
        offs.sort();
        if ($urandom_range(0, 2) == 0)
        begin
            offs[0]      = 16'h0000;
            offs[used-1] = 16'hFFFF;
        end
        if (used > 2 && $urandom_range(0, 4) == 0)
            offs[2] = offs[1];
        for (k = 0; k < used; k++)
            send_word(make_stop(k, int'(offs[k]), COL_W'($urandom)));

        lo = cfg_top;
        hi = cfg_top + cfg_h + 2;
        if (hi > 8191)
            hi = 8191;
        for (k = 0; k < WORDS_PER_PHASE; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_word(make_stop($urandom_range(0, 15), $urandom, COL_W'($urandom)));
            else if (pick < 85)
                send_word(make_shade($urandom_range(lo, hi)));
            else
                send_word(make_shade($urandom_range(0, 8191)));
        end
    endtask

    task automatic test_random_traffic();
        int p;
        for (p = 0; p < PHASES; p++)
            run_random_phase(p);
    endtask

    // ------------------------------------------------------------------
    // receiver stall pattern: always ready, coin flip, mostly stalled, or a counter bit turning it on and off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pat_cnt <= pat_cnt + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= pat_cnt[2];
        endcase
    end

    // result check: each color word against the oldest owed color
    always @(posedge clk)
    begin
        msg_pkg::out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (colors_due.size() == 0)
                report_mismatch("unexpected color word", int'(out_data), 0);
            else
            begin
                want = colors_due.pop_front();
                if (out_data.red !== want.red)
                    report_mismatch("red", int'(out_data.red), int'(want.red));
                if (out_data.green !== want.green)
                    report_mismatch("green", int'(out_data.green), int'(want.green));
                if (out_data.blue !== want.blue)
                    report_mismatch("blue", int'(out_data.blue), int'(want.blue));
            end
        end
    end

    // hang guard: no word moving on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_stop_table();
        test_rect_edges();
        test_stop_count_limits();
        test_stop_reach();
        test_zero_height();
        test_random_traffic();

        settle();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/msg_pkg.sv
hdl/msg_blend_lane.sv
hdl/msg_ctrl.sv
hdl/msg_datapath.sv
hdl/multi_stop_gradient_shader.sv
test/tb.sv
